[rtl/tpr_pkg.sv]
// Shared constants, action codes and inter-module structs of the token prefix reuse tracker.
`default_nettype none
package tpr_pkg;

	localparam int unsigned MaxTokens = 4096;
	localparam int unsigned AddrW     = $clog2(MaxTokens);
	localparam int unsigned LenW      = 13;
	localparam int unsigned PosW      = 16;
	localparam int unsigned IdW       = 32;
	localparam int unsigned CfgAddrW  = 3;
	localparam int unsigned CfgDataW  = 32;

	// Register index of the capacity register on the configuration port.
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [2:0] {
		ACT_RECORD      = 3'd0,
		ACT_QUERY       = 3'd1,
		ACT_CLEAR       = 3'd2,
		ACT_TAINT       = 3'd3,
		ACT_TRUNCATE    = 3'd4,
		ACT_RESET_STORE = 3'd5
	} action_t;

	typedef logic [LenW-1:0]  len_t;
	typedef logic [AddrW-1:0] addr_t;

	// Request to zero the store from a slot up to the last one.
	typedef struct packed {
		logic  start;
		addr_t from;
	} sweep_req_t;

	// One query item on its way to the compare stage.
	typedef struct packed {
		logic           fresh;
		logic           cmp_en;
		logic           last;
		logic           cand;
		len_t           plen;
		logic [IdW-1:0] id;
	} query_item_t;

endpackage
`default_nettype wire

[rtl/tpr_store.sv]
// Token store memory with its zeroing sweep.
`default_nettype none
module tpr_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tpr_pkg::sweep_req_t    sweep_req,
	input  logic                   wr_en,
	input  tpr_pkg::addr_t         wr_addr,
	input  logic [tpr_pkg::IdW-1:0] wr_data,
	input  logic                   rd_en,
	input  tpr_pkg::addr_t         rd_addr,
	output logic [tpr_pkg::IdW-1:0] rd_data,
	output logic                   busy
);
	import tpr_pkg::*;

	logic [IdW-1:0] store_q [MaxTokens];
	logic [IdW-1:0] rd_data_q;
	logic           sweep_q;
	addr_t          sweep_addr_q;

	// Sweep one entry per cycle up to the top slot; a new request restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_req.start) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= sweep_req.from;
		end else if (sweep_q) begin
			if (sweep_addr_q == AddrW'(MaxTokens - 1)) begin
				sweep_q <= 1'b0;
			end
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			store_q[sweep_addr_q] <= '0;
		end else if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = sweep_q;

endmodule
`default_nettype wire

[rtl/tpr_match.sv]
// Query compare stage, running match flag and answer register.
`default_nettype none
module tpr_match (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  tpr_pkg::query_item_t    item_in,
	input  logic [tpr_pkg::IdW-1:0] rd_data,
	input  logic                    out_stall,
	output logic                    out_valid,
	output tpr_pkg::len_t           reuse_length,
	output tpr_pkg::len_t           stored_length,
	output logic                    busy
);
	import tpr_pkg::*;

	logic        valid_s1;
	query_item_t item_s1;
	logic        match_q;
	logic        out_valid_q;
	len_t        reuse_q;
	len_t        stored_q;

	logic hold;
	logic retire_answer;
	logic match_prev;
	logic match_new;

	always_comb begin
		hold          = valid_s1 & item_s1.last & out_valid_q & out_stall;
		match_prev    = item_s1.fresh | match_q;
		match_new     = match_prev & (~item_s1.cmp_en | (rd_data == item_s1.id));
		retire_answer = valid_s1 & item_s1.last & ~hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			match_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold) begin
				valid_s1 <= load;
				if (valid_s1) begin
					match_q <= item_s1.last ? 1'b1 : match_new;
				end
			end
			if (retire_answer) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
		if (retire_answer) begin
			reuse_q  <= (item_s1.cand & match_new) ? item_s1.plen : '0;
			stored_q <= item_s1.plen;
		end
	end

	assign out_valid     = out_valid_q;
	assign reuse_length  = reuse_q;
	assign stored_length = stored_q;
	// Hold off new items while an answer sits behind a full output register.
	assign busy          = valid_s1 & item_s1.last & out_valid_q;

endmodule
`default_nettype wire

[rtl/token_prefix_reuse_tracker.sv]
// Top level of the token prefix reuse tracker: run control, capacity register, store and match.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_stall   | action, start_pos, run_length, token_id, keep_length
//  out     | out_valid / out_stall | reuse_length, stored_length
//  cfg     | psel/penable/pwrite   | paddr, pwdata, prdata, pready (capacity at 0x0)
//
// Record, query, clear and taint items are taken one per cycle while in_stall is low. A
// query's answer lands in the output register from the compare stage, which holds while
// the output stalls; the token store read is registered and the compare runs in that stage.
// Reset, a capacity write and reset_store zero all 4096 slots, one per cycle, and
// truncate zeroes from the kept length up to slot 4095; in_stall is high meanwhile.
// in_stall also rises while a finished answer waits behind an unread result.
`default_nettype none
module token_prefix_reuse_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    action,
	input  logic [tpr_pkg::PosW-1:0]      start_pos,
	input  logic [tpr_pkg::PosW-1:0]      run_length,
	input  logic signed [tpr_pkg::IdW-1:0] token_id,
	input  logic [tpr_pkg::PosW-1:0]      keep_length,
	// result items
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tpr_pkg::LenW-1:0]      reuse_length,
	output logic [tpr_pkg::LenW-1:0]      stored_length,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpr_pkg::CfgAddrW-1:0]  paddr,
	input  logic [tpr_pkg::CfgDataW-1:0]  pwdata,
	output logic [tpr_pkg::CfgDataW-1:0]  prdata,
	output logic                          pready
);
	import tpr_pkg::*;

	// Architectural state.
	len_t            cap_q;
	len_t            plen_q;
	logic            taint_q;
	logic [PosW-1:0] run_off_q;
	logic            run_drop_q;
	logic            run_query_q;

	len_t            plen_d;
	logic            taint_d;
	logic [PosW-1:0] run_off_d;
	logic            run_drop_d;
	logic            run_query_d;

	logic            store_busy;
	logic            match_busy;
	logic            accept;
	logic            cfg_wr;

	// Per-item decode.
	len_t            eff_cap;
	logic            cap_zero;
	logic            is_query;
	logic            n_zero;
	logic            fresh;
	logic [PosW-1:0] off;
	logic            drop;
	logic [PosW:0]   off_inc;
	logic            last;
	logic [PosW:0]   idx;
	logic [PosW:0]   sum_sn;
	logic            ovf;
	logic            drop_now;
	logic            drop_new;
	len_t            keep_a;
	len_t            keep_min;

	sweep_req_t      sweep_req;
	logic            wr_en;
	logic            rd_en;
	logic [IdW-1:0]  rd_data;
	query_item_t     qitem;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);
	assign prdata   = (paddr[2] == REG_CAPACITY) ? {{(CfgDataW - LenW){1'b0}}, cap_q} : '0;
	assign in_stall = store_busy | match_busy;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		eff_cap  = (cap_q > LenW'(MaxTokens)) ? LenW'(MaxTokens) : cap_q;
		cap_zero = (eff_cap == '0);
		is_query = (action == ACT_QUERY);
		n_zero   = (run_length == '0);
		// A run continues only if the previous item was of the same kind and mid-run.
		fresh    = (run_off_q == '0) | (run_query_q != is_query);
		off      = fresh ? '0 : run_off_q;
		drop     = ~fresh & run_drop_q;
		off_inc  = {1'b0, off} + 1'b1;
		last     = off_inc >= {1'b0, run_length};
		idx      = {1'b0, start_pos} + {1'b0, off};
		sum_sn   = {1'b0, start_pos} + {1'b0, run_length};
		ovf      = ({1'b0, start_pos} >= (PosW+1)'(eff_cap)) |
		           ({1'b0, run_length} > ((PosW+1)'(eff_cap) - {1'b0, start_pos}));
		drop_now = ~drop & (ovf | (idx >= (PosW+1)'(eff_cap)));
		drop_new = drop | drop_now;
		keep_a   = (keep_length > {{(PosW - LenW){1'b0}}, plen_q}) ?
		           plen_q : keep_length[LenW-1:0];
		keep_min = (keep_a > eff_cap) ? eff_cap : keep_a;
	end

	// Store write on a record item that stays in range.
	assign wr_en = accept & (action == ACT_RECORD) & ~cap_zero & ~n_zero & ~drop_now & ~drop;

	// Query item for the compare stage; an empty query answers zero at once.
	always_comb begin
		qitem.fresh  = fresh | n_zero;
		qitem.cmp_en = ~n_zero & (off < {{(PosW - LenW){1'b0}}, plen_q}) &
		               (off < PosW'(MaxTokens));
		qitem.last   = n_zero | last;
		qitem.cand   = ~n_zero & last & ~cap_zero & ~taint_q & (plen_q != '0) &
		               ({{(PosW - LenW){1'b0}}, plen_q} < run_length);
		qitem.plen   = plen_q;
		qitem.id     = token_id;
	end

	assign rd_en = accept & is_query & qitem.cmp_en;

	// Next state of the run and the prefix bookkeeping.
	always_comb begin
		plen_d          = plen_q;
		taint_d         = taint_q;
		run_off_d       = run_off_q;
		run_drop_d      = run_drop_q;
		run_query_d     = run_query_q;
		sweep_req.start = 1'b0;
		sweep_req.from  = '0;
		if (cfg_wr) begin
			// Reallocate: wipe everything and drop any run.
			plen_d          = '0;
			taint_d         = 1'b0;
			run_off_d       = '0;
			run_drop_d      = 1'b0;
			run_query_d     = 1'b0;
			sweep_req.start = 1'b1;
		end else if (accept) begin
			run_off_d   = '0;
			run_drop_d  = 1'b0;
			run_query_d = 1'b0;
			unique case (action)
				ACT_RECORD: begin
					if (!cap_zero && !n_zero) begin
						if (drop_now) begin
							plen_d = '0;
						end
						if (last) begin
							if (!drop_new && (sum_sn > {{(PosW + 1 - LenW){1'b0}}, plen_q})) begin
								plen_d = sum_sn[LenW-1:0];
							end
						end else begin
							run_off_d  = off_inc[PosW-1:0];
							run_drop_d = drop_new;
						end
					end
				end
				ACT_QUERY: begin
					if (!n_zero && !last) begin
						run_off_d   = off_inc[PosW-1:0];
						run_query_d = 1'b1;
					end
				end
				ACT_CLEAR: begin
					plen_d  = '0;
					taint_d = 1'b0;
				end
				ACT_TAINT: begin
					taint_d = 1'b1;
				end
				ACT_TRUNCATE: begin
					if (!cap_zero) begin
						plen_d = keep_min;
						// Zero everything past the kept prefix.
						if (keep_min < LenW'(MaxTokens)) begin
							sweep_req.start = 1'b1;
							sweep_req.from  = keep_min[AddrW-1:0];
						end
					end
				end
				ACT_RESET_STORE: begin
					plen_d          = '0;
					taint_d         = 1'b0;
					sweep_req.start = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= LenW'(MaxTokens);
			plen_q      <= '0;
			taint_q     <= 1'b0;
			run_off_q   <= '0;
			run_drop_q  <= 1'b0;
			run_query_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q <= pwdata[LenW-1:0];
			end
			plen_q      <= plen_d;
			taint_q     <= taint_d;
			run_off_q   <= run_off_d;
			run_drop_q  <= run_drop_d;
			run_query_q <= run_query_d;
		end
	end

	tpr_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.sweep_req (sweep_req),
		.wr_en     (wr_en),
		.wr_addr   (idx[AddrW-1:0]),
		.wr_data   (token_id),
		.rd_en     (rd_en),
		.rd_addr   (off[AddrW-1:0]),
		.rd_data   (rd_data),
		.busy      (store_busy)
	);

	tpr_match u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept & is_query),
		.item_in       (qitem),
		.rd_data       (rd_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.reuse_length  (reuse_length),
		.stored_length (stored_length),
		.busy          (match_busy)
	);

endmodule
`default_nettype wire

[tb/sv/token_prefix_reuse_tracker_checker.sv]
// Prefix tracker scoreboard: mirrors the token store, predicts query answers and checks them.
`timescale 1ns / 1ps
module token_prefix_reuse_tracker_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [2:0]                     action,
	input  logic [tpr_pkg::PosW-1:0]       start_pos,
	input  logic [tpr_pkg::PosW-1:0]       run_length,
	input  logic signed [tpr_pkg::IdW-1:0] token_id,
	input  logic [tpr_pkg::PosW-1:0]       keep_length,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [tpr_pkg::LenW-1:0]       reuse_length,
	input  logic [tpr_pkg::LenW-1:0]       stored_length,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tpr_pkg::CfgAddrW-1:0]   paddr,
	input  logic [tpr_pkg::CfgDataW-1:0]   pwdata,
	input  logic [tpr_pkg::CfgDataW-1:0]   prdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             pending
);
	import tpr_pkg::*;

	typedef struct packed {
		len_t reuse;
		len_t stored;
	} answer_t;

	logic [IdW-1:0] slot_id  [MaxTokens];
	bit             slot_set [MaxTokens];
	len_t           cap_reg;
	int unsigned    prefix_len;
	bit             tainted;
	int unsigned    run_pos;
	bit             run_lost;
	bit             run_match;
	bit             run_query;
	answer_t        answer_q [$];

	function automatic int unsigned usable_slots();
		return (32'(cap_reg) > MaxTokens) ? MaxTokens : 32'(cap_reg);
	endfunction

	task automatic close_run();
		run_pos   = 0;
		run_lost  = 1'b0;
		run_match = 1'b1;
		run_query = 1'b0;
	endtask

	task automatic open_run(input bit query);
		if (run_pos == 0 || run_query != query) begin
			close_run();
			run_query = query;
		end
	endtask

	task automatic clear_slots_from(input int unsigned first);
		for (int unsigned i = first; i < MaxTokens; i++) begin
			slot_id[i]  = '0;
			slot_set[i] = 1'b0;
		end
	endtask

	task automatic wipe_store();
		clear_slots_from(0);
		prefix_len = 0;
		tainted    = 1'b0;
	endtask

	task automatic record_token(input int unsigned s, input int unsigned n,
			input logic [IdW-1:0] id);
		int unsigned cap;
		int unsigned idx;
		cap = usable_slots();
		if (cap == 0 || n == 0) begin
			close_run();
			return;
		end
		open_run(1'b0);
		if (!run_lost) begin
			idx = s + run_pos;
			if (s >= cap || n > cap - s || idx >= cap) begin
				prefix_len = 0;
				run_lost   = 1'b1;
			end else begin
				slot_id[idx]  = id;
				slot_set[idx] = 1'b1;
			end
		end
		run_pos++;
		if (run_pos >= n) begin
			if (!run_lost && s + n > prefix_len)
				prefix_len = s + n;
			close_run();
		end
	endtask

	task automatic query_token(input int unsigned n, input logic [IdW-1:0] id);
		int unsigned    cap;
		logic [IdW-1:0] held;
		answer_t        ans;
		cap = usable_slots();
		if (n == 0) begin
			close_run();
			ans.reuse  = '0;
			ans.stored = len_t'(prefix_len);
			answer_q.push_back(ans);
			return;
		end
		open_run(1'b1);
		if (run_pos < prefix_len && run_pos < MaxTokens) begin
			held = slot_set[run_pos] ? slot_id[run_pos] : '0;
			if (held != id)
				run_match = 1'b0;
		end
		run_pos++;
		if (run_pos >= n) begin
			ans.stored = len_t'(prefix_len);
			if (cap != 0 && !tainted && prefix_len > 0 && prefix_len < n && run_match)
				ans.reuse = len_t'(prefix_len);
			else
				ans.reuse = '0;
			close_run();
			answer_q.push_back(ans);
		end
	endtask

	task automatic apply_item(input logic [2:0] act, input int unsigned s,
			input int unsigned n, input logic [IdW-1:0] id, input int unsigned keep);
		int unsigned kept;
		case (act)
			ACT_RECORD: record_token(s, n, id);
			ACT_QUERY:  query_token(n, id);
			default: begin
				close_run();
				case (act)
					ACT_CLEAR: begin
						prefix_len = 0;
						tainted    = 1'b0;
					end
					ACT_TAINT: tainted = 1'b1;
					ACT_TRUNCATE: begin
						if (usable_slots() != 0) begin
							kept = keep;
							if (kept > prefix_len)
								kept = prefix_len;
							if (kept > usable_slots())
								kept = usable_slots();
							clear_slots_from(kept);
							prefix_len = kept;
						end
					end
					ACT_RESET_STORE: wipe_store();
					default: ;
				endcase
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			cap_reg = len_t'(MaxTokens);
			wipe_store();
			close_run();
			answer_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pready && paddr[CfgAddrW-1:2] == REG_CAPACITY) begin
				if (pwrite) begin
					cap_reg = pwdata[LenW-1:0];
					wipe_store();
					close_run();
				end else if (prdata !== CfgDataW'(cap_reg)) begin
					fail_count++;
					$display("%0t: capacity readback mismatch, expected %0d, actual %0d",
						$time, cap_reg, prdata);
				end
			end
			if (in_valid && !in_stall)
				apply_item(action, 32'(start_pos), 32'(run_length), token_id,
					32'(keep_length));
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected, actual reuse %0d stored %0d",
						$time, reuse_length, stored_length);
				end else begin
					want = answer_q.pop_front();
					if (want.reuse !== reuse_length) begin
						fail_count++;
						$display("%0t: reuse_length mismatch, expected %0d, actual %0d",
							$time, want.reuse, reuse_length);
					end
					if (want.stored !== stored_length) begin
						fail_count++;
						$display("%0t: stored_length mismatch, expected %0d, actual %0d",
							$time, want.stored, stored_length);
					end
				end
			end
			pending <= answer_q.size();
		end
	end

endmodule

[tb/sv/token_prefix_reuse_tracker_test.sv]
// Test top for the prefix tracker: drives items and capacity writes, stalls results, reports.
`timescale 1ns / 1ps
module token_prefix_reuse_tracker_test;
	import tpr_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam int unsigned PHASE_ITEMS  = 95;
	// a store wipe sweeps all 4096 slots, a truncate those past the kept length; let one finish before a write
	localparam int unsigned SWEEP_WAIT   = 4200;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TAIL_CYCLES  = 16;
	localparam logic [2:0]  ACT_SPARE_6  = 3'd6;
	localparam logic [2:0]  ACT_SPARE_7  = 3'd7;
	localparam logic [CfgAddrW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [2:0]             action;
	logic [PosW-1:0]        start_pos;
	logic [PosW-1:0]        run_length;
	logic signed [IdW-1:0]  token_id;
	logic [PosW-1:0]        keep_length;
	logic                   out_valid;
	logic                   out_stall;
	logic [LenW-1:0]        reuse_length;
	logic [LenW-1:0]        stored_length;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CfgAddrW-1:0]    paddr;
	logic [CfgDataW-1:0]    pwdata;
	logic [CfgDataW-1:0]    prdata;
	logic                   pready;

	int                     fail_count;
	int                     pending;
	int unsigned            cycle_count = 0;
	int unsigned            cur_cap;
	int unsigned            phase_items;
	bit                     no_idle;
	logic [31:0]            tok_seed;
	int                     squeeze_cnt  = 0;
	int                     squeeze_seen = 0;

	always #5 clk = ~clk;

	token_prefix_reuse_tracker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.start_pos    (start_pos),
		.run_length   (run_length),
		.token_id     (token_id),
		.keep_length  (keep_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reuse_length (reuse_length),
		.stored_length(stored_length),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	token_prefix_reuse_tracker_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.start_pos    (start_pos),
		.run_length   (run_length),
		.token_id     (token_id),
		.keep_length  (keep_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reuse_length (reuse_length),
		.stored_length(stored_length),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Bound the run: a hung handshake or a missing answer ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("token_prefix_reuse_tracker verification failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Token id the scheduler would feed for a prompt position; record runs and
	// query runs share it so that prompts really do hit the cached prefix.
	function automatic logic [31:0] prompt_id(input int unsigned pos);
		return tok_seed ^ (pos * 32'h9E37_79B9);
	endfunction

	// Offer one item, hold it until taken, then idle for a random gap.
	task automatic send_item(input logic [2:0] act, input int unsigned s,
			input int unsigned n, input logic [31:0] id, input int unsigned keep);
		int unsigned gap;
		in_valid    <= 1'b1;
		action      <= act;
		start_pos   <= PosW'(s);
		run_length  <= PosW'(n);
		token_id    <= id;
		keep_length <= PosW'(keep);
		do
			@(posedge clk);
		while (in_stall);
		phase_items++;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain every answer and let any sweep finish before touching the register.
	task automatic settle();
		drop_valid();
		while (pending != 0)
			@(posedge clk);
		repeat (SWEEP_WAIT) @(posedge clk);
	endtask

	// One register access: setup, access until pready, then an idle gap.
	task automatic cap_access(input bit wr, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CAP_ADDR;
		pwdata  <= wr ? CfgDataW'(value) : '0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (wr)
			cur_cap = (value > MaxTokens) ? MaxTokens : value;
		@(posedge clk);
	endtask

	// Record run of count items; a few items carry a stray id or shifted fields.
	task automatic record_run(input int unsigned s, input int unsigned n,
			input int unsigned count);
		int unsigned s_k;
		int unsigned n_k;
		logic [31:0] id;
		for (int unsigned k = 0; k < count; k++) begin
			s_k = s;
			n_k = n;
			if ($urandom_range(0, 99) < 3)
				s_k = s + $urandom_range(0, 2);
			if ($urandom_range(0, 99) < 3)
				n_k = $urandom_range(1, 12);
			id = ($urandom_range(0, 99) < 3) ? $urandom() : prompt_id(s + k);
			send_item(ACT_RECORD, s_k, n_k, id, $urandom_range(0, 65535));
		end
	endtask

	// Query run of count items: mostly the cached ids, now and then a mismatch.
	task automatic query_run(input int unsigned n, input int unsigned count);
		int unsigned n_k;
		logic [31:0] id;
		for (int unsigned k = 0; k < count; k++) begin
			n_k = n;
			if ($urandom_range(0, 99) < 2)
				n_k = $urandom_range(1, 28);
			id = ($urandom_range(0, 99) < 5) ? $urandom() : prompt_id(k);
			send_item(ACT_QUERY, $urandom_range(0, 65535), n_k, id,
				$urandom_range(0, 65535));
		end
	endtask

	// One random step: a whole run, a broken run, a single command, noise, or a new token seed.
	task automatic random_sequence();
		int unsigned pick;
		int unsigned r;
		int unsigned s;
		int unsigned n;
		int unsigned count;
		int unsigned keep;
		no_idle = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		if (pick < 30) begin
			// scattered start: leaves unwritten slots, or runs off the end
			if (r < 60)
				s = $urandom_range(0, 12);
			else if (r < 85)
				s = (cur_cap > 4) ? cur_cap - $urandom_range(1, 4) : $urandom_range(0, 3);
			else
				s = $urandom_range(0, 65535);
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 10);
			if (n > 24)
				count = $urandom_range(1, 8);
			else if ($urandom_range(0, 9) == 0)
				count = $urandom_range(1, n);
			else
				count = n;
			record_run(s, n, count);
		end else if (pick < 45) begin
			// contiguous refill from slot zero builds a prefix queries can hit
			n = $urandom_range(1, 20);
			record_run(0, n, n);
		end else if (pick < 78) begin
			if (r < 8) begin
				n = 0;
				count = 1;
			end else if (r < 15) begin
				n = $urandom_range(25, 65535);
				count = $urandom_range(1, 6);
			end else begin
				n = $urandom_range(1, 28);
				count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
			end
			query_run(n, count);
		end else if (pick < 83) begin
			send_item(ACT_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom(), $urandom_range(0, 65535));
		end else if (pick < 88) begin
			send_item(ACT_TAINT, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom(), $urandom_range(0, 65535));
		end else if (pick < 90) begin
			if (r < 40)
				keep = $urandom_range(0, 24);
			else if (r < 60)
				keep = 0;
			else
				keep = $urandom_range(0, 65535);
			send_item(ACT_TRUNCATE, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom(), keep);
		end else if (pick < 91) begin
			send_item(ACT_RESET_STORE, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom(), $urandom_range(0, 65535));
		end else if (pick < 93) begin
			send_item((r < 50) ? ACT_SPARE_6 : ACT_SPARE_7, $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom(), $urandom_range(0, 65535));
		end else if (pick < 96) begin
			// zero-length record only ends a run in progress
			send_item(ACT_RECORD, $urandom_range(0, 65535), 0, $urandom(),
				$urandom_range(0, 65535));
		end else begin
			// new scheduler content: cached prefix stops matching
			tok_seed = $urandom();
		end
	endtask

	// Result side: random stalls with stall-free stretches, plus one long hold
	// on request so that answers back up and the block stalls its input.
	initial begin
		int unsigned stall_len;
		int unsigned free_len;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_seen != squeeze_cnt) begin
				squeeze_seen = squeeze_cnt;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall_len = pick_gap();
				free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
					$urandom_range(1, 6);
				if (stall_len != 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat (free_len) @(posedge clk);
			end
		end
	end

	// Stimulus: reset, directed cases, pressure burst, then random phases at
	// different capacities, drain and verdict.
	initial begin
		int unsigned phase_cap [7];
		int unsigned n;
		in_valid    <= 1'b0;
		action      <= ACT_RECORD;
		start_pos   <= '0;
		run_length  <= '0;
		token_id    <= '0;
		keep_length <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		arst_n      <= 1'b0;
		cur_cap     = MaxTokens;
		no_idle     = 1'b0;
		phase_items = 0;
		tok_seed    = $urandom();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty prompt answers at once
		send_item(ACT_QUERY, 0, 0, 0, 0);
		// record two extreme ids, then a prompt one longer than the prefix
		send_item(ACT_RECORD, 0, 2, 32'h8000_0000, 0);
		send_item(ACT_RECORD, 0, 2, 32'h7FFF_FFFF, 0);
		send_item(ACT_QUERY, 65535, 3, 32'h8000_0000, 65535);
		send_item(ACT_QUERY, 65535, 3, 32'h7FFF_FFFF, 65535);
		send_item(ACT_QUERY, 65535, 3, 32'h0000_0000, 65535);
		// a tainted store never gives reuse
		send_item(ACT_TAINT, 0, 0, 0, 0);
		send_item(ACT_QUERY, 0, 3, 32'h8000_0000, 0);
		send_item(ACT_QUERY, 0, 3, 32'h7FFF_FFFF, 0);
		send_item(ACT_QUERY, 0, 3, 32'h0000_0000, 0);
		// clear keeps the slots; extend past them and match all three
		send_item(ACT_CLEAR, 0, 0, 0, 0);
		send_item(ACT_RECORD, 2, 1, 32'hFFFF_FFFF, 0);
		send_item(ACT_QUERY, 0, 4, 32'h8000_0000, 0);
		send_item(ACT_QUERY, 0, 4, 32'h7FFF_FFFF, 0);
		send_item(ACT_QUERY, 0, 4, 32'hFFFF_FFFF, 0);
		send_item(ACT_QUERY, 0, 4, 32'h0000_0000, 0);
		// truncate beyond the prefix, then down to one slot
		send_item(ACT_TRUNCATE, 0, 0, 0, 65535);
		send_item(ACT_TRUNCATE, 0, 0, 0, 1);
		// overflowing start drops the prefix; an unused action ends the run
		send_item(ACT_RECORD, 65535, 65535, 0, 0);
		send_item(ACT_SPARE_7, 0, 0, 0, 0);
		send_item(ACT_RESET_STORE, 0, 0, 0, 0);
		// a long query interrupted by a record run
		send_item(ACT_QUERY, 0, 65535, 0, 0);
		send_item(ACT_RECORD, 0, 1, 0, 0);
		send_item(ACT_RECORD, 0, 0, 32'hFFFF_FFFF, 0);
		send_item(ACT_QUERY, 0, 2, 0, 0);
		send_item(ACT_QUERY, 0, 2, 0, 0);

		// pressure: hold results off while back-to-back queries keep coming
		record_run(0, 4, 4);
		squeeze_cnt++;
		wait (squeeze_seen == squeeze_cnt);
		no_idle = 1'b1;
		repeat (8) begin
			n = $urandom_range(1, 6);
			query_run(n, n);
		end

		phase_cap = '{4096, 24, 0, 1, 4095, 0, 4096};
		phase_cap[5] = $urandom_range(2, 4094);
		for (int ph = 0; ph < 7; ph++) begin
			if (ph != 0) begin
				settle();
				cap_access(1'b1, phase_cap[ph]);
				cap_access(1'b0, 0);
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				random_sequence();
		end

		drop_valid();
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("token_prefix_reuse_tracker verification clean");
		else
			$display("token_prefix_reuse_tracker verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/tpr_pkg.sv
rtl/tpr_store.sv
rtl/tpr_match.sv
rtl/token_prefix_reuse_tracker.sv
tb/sv/token_prefix_reuse_tracker_checker.sv
tb/sv/token_prefix_reuse_tracker_test.sv
